>>> hw/rtl/utf8d_pkg.sv
// Shared constants and types for the UTF-8 stream decoder.
package utf8d_pkg;

	localparam int CP_W = 21;

	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;
	localparam logic [1:0] CONT_TAG = 2'b10;

	localparam logic [CP_W-1:0] MIN_TWO    = 21'h000080;
	localparam logic [CP_W-1:0] MIN_THREE  = 21'h000800;
	localparam logic [CP_W-1:0] MIN_FOUR   = 21'h010000;
	localparam logic [CP_W-1:0] MAX_CP     = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
	localparam logic [CP_W-1:0] REPL_RESET = 21'h00FFFD;

	localparam logic [2:0] LEN_NONE  = 3'd0;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	typedef struct packed {
		logic [2:0]      count;
		logic [1:0]      n_rep;
		logic            tail_repl;
		logic [CP_W-1:0] tail_cp;
		logic            valid_before;
		logic            eot;
	} desc_t;

endpackage

>>> hw/rtl/utf8_stream_decoder.sv
// Top level of the strict UTF-8 stream decoder with replacement.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    data_byte, end_of_text
//  out      source     out_valid / out_ready  code_point, replaced, text_valid,
//                                             run_last, text_last
//  cfg      sink       cfg_valid / cfg_ready  replacement_value
//
// A byte is registered, decoded from that input register, and its results
// leave from a result register one beat per cycle while out_ready is high, so
// a byte that gives several results holds the input until its last beat is
// taken, and one giving at most one result sustains one byte per cycle then.
// Reset leaves no sequence pending, the text marked valid and the replacement
// value at U+FFFD. A stalled output holds its beat and backs up into the input.
module utf8_stream_decoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                data_byte,
	input  logic                      end_of_text,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [utf8d_pkg::CP_W-1:0] code_point,
	output logic                      replaced,
	output logic                      text_valid,
	output logic                      run_last,
	output logic                      text_last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [utf8d_pkg::CP_W-1:0] replacement_value
);
	import utf8d_pkg::*;

	logic            vld_s1;
	logic [7:0]      byte_s1;
	logic            eot_s1;

	logic [CP_W-1:0] repl_q;
	logic [2:0]      rem_q;
	logic [1:0]      idx_q;
	logic [1:0]      nrep_q;
	logic            trepl_q;
	logic [CP_W-1:0] tcp_q;
	logic            vbefore_q;
	logic            eot_q;

	logic            rr_free;
	logic            advance;
	logic            in_rep;
	desc_t           desc;

	assign rr_free   = (rem_q == 3'd0) || ((rem_q == 3'd1) && out_ready);
	assign advance   = vld_s1 & rr_free;
	assign in_ready  = ~vld_s1 | rr_free;
	assign cfg_ready = 1'b1;

	utf8d_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.data_byte   (byte_s1),
		.end_of_text (eot_s1),
		.desc        (desc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			repl_q <= replacement_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eot_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (advance) begin
			rem_q <= desc.count;
			idx_q <= 2'd0;
		end else if (out_valid && out_ready) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			nrep_q    <= desc.n_rep;
			trepl_q   <= desc.tail_repl;
			tcp_q     <= desc.tail_cp;
			vbefore_q <= desc.valid_before;
			eot_q     <= desc.eot;
		end
	end

	// Replacement beats come first; the tail beat, if any, comes last.
	assign in_rep     = (idx_q < nrep_q);
	assign out_valid  = (rem_q != 3'd0);
	assign replaced   = in_rep | trepl_q;
	assign code_point = replaced ? repl_q : tcp_q;
	assign run_last   = (rem_q == 3'd1);
	assign text_last  = run_last & eot_q;
	assign text_valid = vbefore_q & (nrep_q == 2'd0) & ~replaced;

endmodule

>>> hw/rtl/utf8d_core.sv
// Decoder state and the per-byte decode that describes the results of one beat.
module utf8d_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       data_byte,
	input  logic             end_of_text,
	output utf8d_pkg::desc_t desc
);
	import utf8d_pkg::*;

	logic [2:0]      len_q;
	logic [1:0]      taken_q;
	logic [CP_W-1:0] part_q;
	logic            vsf_q;

	logic [2:0]      nxt_len;
	logic [1:0]      nxt_taken;
	logic [CP_W-1:0] nxt_part;
	logic            nxt_vsf;
	logic [1:0]      n_rep;
	logic            has_tail;
	logic            tail_repl;
	logic [CP_W-1:0] tail_cp;
	logic            lead_go;
	logic            is_cont;
	logic            is_final;
	logic            seq_ok;
	logic [1:0]      taken_inc;
	logic [CP_W-1:0] part_ext;
	logic [CP_W-1:0] min_cp;

	assign is_cont   = (data_byte[7:6] == CONT_TAG);
	assign part_ext  = {part_q[CP_W-7:0], data_byte[5:0]};
	assign taken_inc = taken_q + 2'd1;
	assign is_final  = (({1'b0, taken_inc} + 3'd1) == len_q);

	always_comb begin
		case (len_q)
			LEN_TWO:   min_cp = MIN_TWO;
			LEN_THREE: min_cp = MIN_THREE;
			default:   min_cp = MIN_FOUR;
		endcase
	end

	assign seq_ok = (part_ext >= min_cp) && (part_ext <= MAX_CP)
		&& !((part_ext >= SURR_LO) && (part_ext <= SURR_HI));

	always_comb begin
		nxt_len   = len_q;
		nxt_taken = taken_q;
		nxt_part  = part_q;
		n_rep     = 2'd0;
		has_tail  = 1'b0;
		tail_repl = 1'b0;
		tail_cp   = '0;
		lead_go   = 1'b0;

		if (len_q != LEN_NONE) begin
			if (is_cont) begin
				if (is_final) begin
					if (seq_ok) begin
						has_tail = 1'b1;
						tail_cp  = part_ext;
					end else begin
						n_rep     = taken_inc;
						has_tail  = 1'b1;
						tail_repl = 1'b1;
					end
					nxt_len   = LEN_NONE;
					nxt_taken = 2'd0;
					nxt_part  = '0;
				end else begin
					nxt_taken = taken_inc;
					nxt_part  = part_ext;
				end
			end else begin
				// The broken sequence is flushed and the byte starts over as a lead.
				n_rep     = taken_inc;
				nxt_len   = LEN_NONE;
				nxt_taken = 2'd0;
				nxt_part  = '0;
				lead_go   = 1'b1;
			end
		end else begin
			lead_go = 1'b1;
		end

		if (lead_go) begin
			if (!data_byte[7]) begin
				has_tail = 1'b1;
				tail_cp  = {13'd0, data_byte};
			end else if ((data_byte >= LEAD2_LO) && (data_byte <= LEAD2_HI)) begin
				nxt_len  = LEN_TWO;
				nxt_part = {16'd0, data_byte[4:0]};
			end else if ((data_byte >= LEAD3_LO) && (data_byte <= LEAD3_HI)) begin
				nxt_len  = LEN_THREE;
				nxt_part = {17'd0, data_byte[3:0]};
			end else if ((data_byte >= LEAD4_LO) && (data_byte <= LEAD4_HI)) begin
				nxt_len  = LEN_FOUR;
				nxt_part = {18'd0, data_byte[2:0]};
			end else begin
				has_tail  = 1'b1;
				tail_repl = 1'b1;
			end
		end

		if (end_of_text && (nxt_len != LEN_NONE)) begin
			n_rep     = n_rep + nxt_taken;
			has_tail  = 1'b1;
			tail_repl = 1'b1;
		end

		if (end_of_text) begin
			nxt_len   = LEN_NONE;
			nxt_taken = 2'd0;
			nxt_part  = '0;
			nxt_vsf   = 1'b1;
		end else begin
			nxt_vsf = vsf_q & ~((n_rep != 2'd0) | tail_repl);
		end
	end

	always_comb begin
		desc.count        = {1'b0, n_rep} + {2'd0, has_tail};
		desc.n_rep        = n_rep;
		desc.tail_repl    = tail_repl;
		desc.tail_cp      = tail_cp;
		desc.valid_before = vsf_q;
		desc.eot          = end_of_text;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_NONE;
			taken_q <= 2'd0;
			part_q  <= '0;
			vsf_q   <= 1'b1;
		end else if (advance) begin
			len_q   <= nxt_len;
			taken_q <= nxt_taken;
			part_q  <= nxt_part;
			vsf_q   <= nxt_vsf;
		end
	end

endmodule
